### design/sha256_pkg.sv
// sha256_pkg: shared types, constants and round functions for the sha-256 hasher
// no dependencies
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_EMIT
  } ctl_state_t;

  // compression control between sequencer and round unit
  typedef struct packed {
    logic start;
  } comp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } comp_sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS  = 7'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### design/sha256_stream_if.sv
// sha256_stream_if: valid/ready channels, input and output, each carrying one payload struct
// depends on sha256_pkg
interface sha256_in_if (input logic clk);
  import sha256_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha256_out_if (input logic clk);
  import sha256_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/sha256_stream_hasher_top.sv
// sha256_stream_hasher_top: byte-stream sha-256 with a shared round unit
// depends on sha256_pkg, sha256_stream_if, sha256_round
//
// a byte that leaves the block unfilled is only buffered; a byte that fills it also
// runs a compression (accept, start, 64 rounds from the single round unit, fold-in)
// end of message adds the 0x80 marker and zeros at one byte a cycle, then the
// length, one or two compressions, then eight digest transactions
// rst (synchronous) restores the initial hash values and clears counts
module sha256_stream_hasher_top (
  input logic clk,
  input logic rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  ctl_state_t  state, state_next;
  logic [31:0] hstate [8];
  logic [31:0] blk [16];
  logic [5:0]  fill;          // bytes buffered
  logic [60:0] byte_count;
  logic        eom_pend;      // 0x80 marker still to be written
  logic        pad_act;       // end of message seen, padding under way
  logic        final_blk;     // block now padding or compressing carries the length
  logic [2:0]  widx;
  logic [31:0] vars [8];
  comp_req_t   req;
  comp_sts_t   sts;

  logic        take;
  logic        byte_put;
  logic [7:0]  put_val;
  logic [63:0] bits;

  sha256_round u_round (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .blk  (blk),
    .hin  (hstate),
    .vars (vars),
    .sts  (sts)
  );

  assign take = in_ch.valid && in_ch.ready;
  assign bits = {byte_count, 3'b000};

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (in_ch.data.byte_valid && fill == 6'd63) state_next = ST_COMP;
          else if (in_ch.data.end_of_message) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        // marker then zeros, up to the length slot in the last block, else to block end
        if ({1'b0, fill} == LEN_POS && final_blk) state_next = ST_LEN;
        else if (fill == 6'd63) state_next = ST_COMP;
      end
      ST_LEN: state_next = ST_COMP;
      ST_COMP: begin
        if (sts.done) begin
          if (final_blk) state_next = ST_EMIT;
          else if (pad_act) state_next = ST_PAD;
          else state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready && widx == 3'd7) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output and control decode
  always_comb begin
    in_ch.ready = 1'b0;
    req.start   = 1'b0;
    byte_put    = 1'b0;
    put_val     = 8'h00;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (take && in_ch.data.byte_valid) begin
          byte_put = 1'b1;
          put_val  = in_ch.data.msg_byte;
        end
      end
      ST_PAD: begin
        if (!({1'b0, fill} == LEN_POS && final_blk)) begin
          byte_put = 1'b1;
          put_val  = eom_pend ? PAD_BYTE : 8'h00;
        end
      end
      // start on entry, once the buffer holds its last write
      ST_COMP: req.start = !sts.busy && !sts.done;
      default: ;
    endcase
  end

  assign out_ch.valid = (state == ST_EMIT);
  assign out_ch.data.digest_word = hstate[widx];
  assign out_ch.data.word_index  = widx;
  assign out_ch.data.last_word   = (widx == 3'd7);

  // block buffer; a byte at a word start clears the rest of the word
  always_ff @(posedge clk) begin
    if (byte_put) begin
      if (fill[1:0] == 2'd0)
        blk[fill[5:2]] <= {put_val, 24'h0};
      else
        blk[fill[5:2]][8*(3-fill[1:0]) +: 8] <= put_val;
    end else if (state == ST_LEN) begin
      blk[14] <= bits[63:32];
      blk[15] <= bits[31:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      eom_pend   <= 1'b0;
      pad_act    <= 1'b0;
      final_blk  <= 1'b0;
      widx       <= '0;
      hstate     <= INIT_HASH;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (in_ch.data.byte_valid) begin
              fill       <= fill + 6'd1;
              byte_count <= byte_count + 61'd1;
            end
            eom_pend  <= in_ch.data.end_of_message;
            pad_act   <= in_ch.data.end_of_message;
            final_blk <= 1'b0;
          end
        end
        ST_PAD: begin
          if (byte_put) begin
            fill <= fill + 6'd1;
            if (eom_pend) begin
              // this write is the 0x80 byte
              eom_pend  <= 1'b0;
              final_blk <= ({1'b0, fill} + 7'd1 <= LEN_POS);
            end
          end
        end
        ST_LEN: fill <= '0;
        ST_COMP: begin
          if (sts.done) begin
            for (int i = 0; i < 8; i++) hstate[i] <= hstate[i] + vars[i];
            fill <= '0;
            // a block closed by the marker with no room for the length
            if (pad_act && !eom_pend) final_blk <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              hstate     <= INIT_HASH;
              byte_count <= '0;
              fill       <= '0;
              final_blk  <= 1'b0;
              pad_act    <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### design/sha256_round.sv
// sha256_round: one shared round unit, 64 rounds per block, one a cycle
// depends on sha256_pkg
module sha256_round (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::comp_req_t  req,
  input  logic [31:0]            blk [16],
  input  logic [31:0]            hin [8],
  output logic [31:0]            vars [8],
  output sha256_pkg::comp_sts_t  sts
);
  import sha256_pkg::*;

  logic [31:0] win [16];
  logic [5:0]  rnd;
  logic        busy;
  logic        done;
  logic [31:0] w_cur, t1, t2, w_new;

  always_comb begin
    w_new = win[0] + ssig0(win[1]) + win[9] + ssig1(win[14]);
    w_cur = win[0];
    t1 = vars[7] + bsig1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
       + ROUND_K[rnd] + w_cur;
    t2 = bsig0(vars[0]) + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
  end

  // window shifts down each round; slot 15 takes the next schedule word
  always_ff @(posedge clk) begin
    if (req.start) begin
      win  <= blk;
      vars <= hin;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_new;
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

### test/sha256_hasher_sb.sv
// sha256_hasher_sb: digest predictor and expected-word store for the hasher bench
// depends on sha256_pkg
`timescale 1ns / 1ps
class sha256_hasher_sb;
  logic [31:0] chain[8];
  logic [31:0] blk[16];
  int unsigned fill;
  logic [60:0] nbytes;
  sha256_pkg::out_item_t digest_q[$];
  int errors;

  function new();
    reset();
    errors = 0;
  endfunction

  function void reset();
    for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::INIT_HASH[i];
    fill = 0;
    nbytes = '0;
  endfunction

  static function logic [31:0] rr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void put(logic [7:0] b);
    int w;
    int sh;
    w = fill / 4;
    sh = (3 - fill % 4) * 8;
    if (fill % 4 == 0) blk[w] = 32'(b) << sh;
    else blk[w] = blk[w] | (32'(b) << sh);
    fill++;
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10));
    v = chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + w[t];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  // accepted input transaction
  function void note_input(sha256_pkg::in_item_t it);
    logic [63:0] bits;
    sha256_pkg::out_item_t o;
    if (it.byte_valid) begin
      put(it.msg_byte);
      nbytes = nbytes + 1;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!it.end_of_message) return;
    bits = {nbytes, 3'b000};
    put(sha256_pkg::PAD_BYTE);
    if (fill > 56) begin
      while (fill < 64) put(8'h00);
      compress();
      fill = 0;
    end
    while (fill < 56) put(8'h00);
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      digest_q.push_back(o);
    end
    reset();
  endfunction

  function void report(string what);
    $display("mismatch: %s", what);
    errors++;
  endfunction

  function void check_word(sha256_pkg::out_item_t got);
    sha256_pkg::out_item_t exp;
    if (digest_q.size() == 0) begin
      report($sformatf("unexpected word %h", got.digest_word));
      return;
    end
    exp = digest_q.pop_front();
    if (got.digest_word !== exp.digest_word)
      report($sformatf("digest_word got %h exp %h", got.digest_word, exp.digest_word));
    if (got.word_index !== exp.word_index)
      report($sformatf("word_index got %0d exp %0d", got.word_index, exp.word_index));
    if (got.last_word !== exp.last_word)
      report($sformatf("last_word got %b exp %b", got.last_word, exp.last_word));
  endfunction
endclass

### test/sha256_stream_hasher_top_tb.sv
// sha256_stream_hasher_top_tb: random and directed byte streams against a digest predictor
// depends on sha256_pkg, sha256_stream_if, sha256_hasher_sb and the hasher rtl
`timescale 1ns / 1ps
module sha256_stream_hasher_top_tb;
  import sha256_pkg::*;

  logic clk = 0;
  logic rst = 1;
  always #6 clk = ~clk;

  sha256_in_if  in_ch (clk);
  sha256_out_if out_ch (clk);

  sha256_stream_hasher_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sha256_hasher_sb sb = new();
  int idle_cycles = 0;
  int sent = 0;
  localparam int IDLE_LIMIT = 20000;

  // input side: one transaction offered, held until accepted
  task automatic send_byte(logic [7:0] b, logic v, logic eom);
    in_item_t it;
    it.msg_byte = b;
    it.byte_valid = v;
    it.end_of_message = eom;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    sent++;
    // random gap between bursts, valid stays high inside a burst
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_message(int len, bit empty_tail);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), 1'b1, (i == len - 1) && !empty_tail);
    if (empty_tail || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // output side: own stall pattern, plus one long hold-off
  bit long_hold = 0;
  initial begin
    out_ch.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(0, 3) != 0) || (sent > 200);
    end
  end

  // sampling on the edge: a transaction is complete when both are high
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
    if (!rst && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog on cycles with no progress
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[sha256_stream_hasher_top] ERROR");
    $finish;
  end

  initial begin
    in_item_t zero;
    int len;
    zero = '0;
    in_ch.valid = 0;
    in_ch.data = zero;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, idle item, extreme bytes, padding spill into a second block
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h62, 1'b1, 1'b0);
    send_byte(8'h63, 1'b1, 1'b1);
    send_message(56, 0);

    // long hold-off on the receiver while the sender keeps offering
    long_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      begin
        send_message(3, 0);
        send_message(2, 1);
        send_message(1, 0);
      end
    join

    // random short messages
    while (sent < 100) begin
      len = $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
      send_message(len, $urandom_range(0, 3) == 0);
    end
    in_ch.valid <= 1'b0;

    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("[sha256_stream_hasher_top] OK");
    else $display("[sha256_stream_hasher_top] ERROR");
    $finish;
  end
endmodule
